// ===== hdl/group_sum_top_n_per_hour_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the group sum top-n core
// Shared concurrent assertion shorthands, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef GROUP_SUM_TOP_N_PER_HOUR_CORE_MACROS_SVH
`define GROUP_SUM_TOP_N_PER_HOUR_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GSTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the condition.
`define GSTK_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hdl/gstk_pkg.sv =====
// ----------------------------------------------------------------------------
// gstk_pkg
// Types and constants shared by the group sum top-n core and its table.
// ----------------------------------------------------------------------------
`default_nettype none

package gstk_pkg;

  localparam int DEFAULT_ENTRIES = 64;
  localparam int HOUR_W  = 32;
  localparam int LIGHT_W = 16;
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 32;
  localparam int TOP_N_W = 7;

  localparam logic [TOP_N_W-1:0] TOP_N_RESET = 7'd2;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 32'hFFFF_FFFF;

  // Register word index taken from paddr[2].
  localparam logic REG_TOP_N = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_UPD,
    ST_INS,
    ST_SEL,
    ST_DEC,
    ST_CLR
  } state_t;

  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [LIGHT_W-1:0] light;
    logic [TOTAL_W-1:0] total;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/gstk_table.sv =====
// ----------------------------------------------------------------------------
// gstk_table
// Pair table memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gstk_table #(
  parameter int ENTRIES = gstk_pkg::DEFAULT_ENTRIES,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire gstk_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output gstk_pkg::entry_t     rdata
);

  gstk_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/group_sum_top_n_per_hour_core.sv =====
// Flow: a record scans the stored pairs through the table read port, one per
// cycle, until a match or the last pair. A last record then adds selection
// passes over the table, one pair picked per pass and a final pass that finds none,
// plus output stalls and a clear state.
// Throughput: one record at a time; a new record is accepted only in the idle state.
// Reset (rst, synchronous, active high) empties the table and clears the overflow
// flag; top_n returns to 2.
// ----------------------------------------------------------------------------
// group_sum_top_n_per_hour_core
// Sums counts per hour and light pair, then emits the top pairs of each hour.
// ----------------------------------------------------------------------------
`default_nettype none
`include "group_sum_top_n_per_hour_core_macros.svh"

module group_sum_top_n_per_hour_core #(
  parameter int ENTRIES = gstk_pkg::DEFAULT_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // hour_key[31:0], light_id[47:32], vehicle_count[63:48]
  input  wire logic        s_tlast,   // is_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // out_hour[31:0], out_light[47:32], total[79:48]
  output logic             m_tuser,   // overflow
  output logic             m_tlast,   // last_result
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  gstk_pkg::state_t state, state_next;

  logic [gstk_pkg::TOP_N_W-1:0] top_n;
  logic [CW-1:0]  used;
  logic           overflow_seen;

  logic [gstk_pkg::HOUR_W-1:0]  in_hour;
  logic [gstk_pkg::LIGHT_W-1:0] in_light;
  logic [gstk_pkg::COUNT_W-1:0] in_count;
  logic                         in_last;

  logic [CW-1:0]  rd_idx;
  logic           pend;
  logic [AW-1:0]  pidx;
  logic [AW-1:0]  widx;
  logic [gstk_pkg::TOTAL_W-1:0] wtot;

  gstk_pkg::entry_t rdata, wdata;
  logic           we;
  logic [AW-1:0]  waddr;

  logic [ENTRIES-1:0] done;
  logic           best_valid;
  logic [AW-1:0]  best_idx;
  gstk_pkg::entry_t best, hold;
  logic           hold_valid;
  logic           have_cur;
  logic [gstk_pkg::HOUR_W-1:0]  cur_hour;
  logic [gstk_pkg::TOP_N_W-1:0] in_cnt;

  logic issue, is_end, match, cand;
  logic new_grp, take, out_free, stall, emit;
  logic [gstk_pkg::TOP_N_W-1:0] base;
  logic [gstk_pkg::TOTAL_W:0] sum;
  logic accept, cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == gstk_pkg::REG_TOP_N);
  assign prdata   = (paddr[2] == gstk_pkg::REG_TOP_N) ? {25'd0, top_n} : 32'd0;
  assign s_tready = (state == gstk_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign issue  = (rd_idx < used);
  assign is_end = pend && ((CW'(pidx) + CW'(1)) == used);
  assign match  = (rdata.hour == in_hour) && (rdata.light == in_light);
  assign cand   = !done[pidx] && (!best_valid || (rdata.hour < best.hour) ||
                  ((rdata.hour == best.hour) && (rdata.total > best.total)));
  assign sum    = {1'b0, wtot} + {17'd0, in_count};

  assign new_grp  = !have_cur || (best.hour != cur_hour);
  assign base     = new_grp ? '0 : in_cnt;
  assign take     = (base < top_n);
  assign out_free = !m_tvalid || m_tready;
  assign stall    = take && hold_valid && !out_free;

  // The held pair goes out when the next one is taken, or at the end of selection.
  assign emit = (state == gstk_pkg::ST_DEC) && hold_valid &&
                (best_valid ? (!stall && take) : out_free);

  // Table write port: update of a matched total, or a new pair at the end.
  always_comb begin
    we    = 1'b0;
    waddr = widx;
    wdata = '{hour: in_hour, light: in_light, total: {16'd0, in_count}};
    if (state == gstk_pkg::ST_UPD) begin
      we          = 1'b1;
      wdata.total = sum[gstk_pkg::TOTAL_W] ? gstk_pkg::TOTAL_MAX
                                           : sum[gstk_pkg::TOTAL_W-1:0];
    end else if (state == gstk_pkg::ST_INS && used < FULL) begin
      we    = 1'b1;
      waddr = used[AW-1:0];
    end
  end

  gstk_table #(.ENTRIES(ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gstk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state) inside
      gstk_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (used == '0) ? gstk_pkg::ST_INS : gstk_pkg::ST_SRCH;
        end
      end
      gstk_pkg::ST_SRCH: begin
        if (pend && match) begin
          state_next = gstk_pkg::ST_UPD;
        end else if (is_end) begin
          state_next = gstk_pkg::ST_INS;
        end
      end
      gstk_pkg::ST_UPD, gstk_pkg::ST_INS: begin
        state_next = in_last ? gstk_pkg::ST_SEL : gstk_pkg::ST_IDLE;
      end
      gstk_pkg::ST_SEL: begin
        if (used == '0) begin
          state_next = gstk_pkg::ST_CLR;
        end else if (is_end) begin
          state_next = gstk_pkg::ST_DEC;
        end
      end
      gstk_pkg::ST_DEC: begin
        if (!best_valid) begin
          if (!hold_valid || out_free) begin
            state_next = gstk_pkg::ST_CLR;
          end
        end else if (!stall) begin
          state_next = gstk_pkg::ST_SEL;
        end
      end
      gstk_pkg::ST_CLR: state_next = gstk_pkg::ST_IDLE;
      default:          state_next = gstk_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      top_n         <= gstk_pkg::TOP_N_RESET;
      used          <= '0;
      overflow_seen <= 1'b0;
      pend          <= 1'b0;
      rd_idx        <= '0;
      done          <= '0;
      best_valid    <= 1'b0;
      hold_valid    <= 1'b0;
      have_cur      <= 1'b0;
      in_cnt        <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        top_n <= pwdata[gstk_pkg::TOP_N_W-1:0];
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == gstk_pkg::ST_SRCH || state == gstk_pkg::ST_SEL) begin
        pend   <= issue;
        rd_idx <= rd_idx + CW'(1);
      end else begin
        pend   <= 1'b0;
        rd_idx <= '0;
      end
      if (state == gstk_pkg::ST_SEL && pend && cand) begin
        best_valid <= 1'b1;
      end
      if (state == gstk_pkg::ST_INS) begin
        if (used < FULL) begin
          used <= used + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (state == gstk_pkg::ST_DEC && best_valid && !stall) begin
        done[best_idx] <= 1'b1;
        have_cur       <= 1'b1;
        in_cnt         <= take ? base + gstk_pkg::TOP_N_W'(1) : base;
        best_valid     <= 1'b0;
        if (take) begin
          hold_valid <= 1'b1;
        end
      end
      if (state == gstk_pkg::ST_CLR) begin
        used       <= '0;
        done       <= '0;
        hold_valid <= 1'b0;
        have_cur   <= 1'b0;
        in_cnt     <= '0;
        best_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_hour  <= s_tdata[31:0];
      in_light <= s_tdata[47:32];
      in_count <= s_tdata[63:48];
      in_last  <= s_tlast;
    end
    if (state == gstk_pkg::ST_SRCH && pend) begin
      widx <= pidx;
      wtot <= rdata.total;
    end
    if (state == gstk_pkg::ST_SRCH || state == gstk_pkg::ST_SEL) begin
      pidx <= rd_idx[AW-1:0];
    end
    if (state == gstk_pkg::ST_SEL && pend && cand) begin
      best     <= rdata;
      best_idx <= pidx;
    end
    if (state == gstk_pkg::ST_DEC) begin
      if (!best_valid) begin
        if (hold_valid && out_free) begin
          m_tdata <= {hold.total, hold.light, hold.hour};
          m_tuser <= overflow_seen;
          m_tlast <= 1'b1;
        end
      end else if (!stall) begin
        cur_hour <= best.hour;
        if (take) begin
          hold <= best;
          if (hold_valid) begin
            m_tdata <= {hold.total, hold.light, hold.hour};
            m_tuser <= overflow_seen;
            m_tlast <= 1'b0;
          end
        end
      end
    end
  end

  `GSTK_ASSERT(a_used_bound, used <= FULL, "pair count exceeds table depth")
  `GSTK_ASSERT_NEXT(a_ovf_sticky, overflow_seen, overflow_seen, "overflow flag dropped")
  `GSTK_ASSERT_NEXT(a_clr_empty, state == gstk_pkg::ST_CLR, used == '0 && !hold_valid,
                    "table not empty after clear")

endmodule

`default_nettype wire
